// ----- design/ble_pkg.sv -----
package ble_pkg;

  localparam int DefCapacity = 64;

  localparam int OpWidth     = 4;
  localparam int ValueWidth  = 32;
  localparam int PosWidth    = 6;
  localparam int StatusWidth = 2;
  localparam int LenWidth    = 7;

  typedef enum logic [OpWidth-1:0] {
    OP_PUSH_HEAD = 4'd0,
    OP_PUSH_TAIL = 4'd1,
    OP_PUSH_BOTH = 4'd2,
    OP_POP_HEAD  = 4'd3,
    OP_POP_TAIL  = 4'd4,
    OP_POP_BOTH  = 4'd5,
    OP_INSERT    = 4'd6,
    OP_COUNT     = 4'd7,
    OP_CONTAINS  = 4'd8,
    OP_IS_SORTED = 4'd9,
    OP_SORT      = 4'd10,
    OP_READ      = 4'd11
  } op_t;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

endpackage

// ----- design/ble_cmp.sv -----
// shared signed comparator used by every walk of the sequencer
module ble_cmp
  import ble_pkg::*;
(
  input  logic [ValueWidth-1:0] a,
  input  logic [ValueWidth-1:0] b,
  output logic                  eq,
  output logic                  gt
);
  assign eq = (a == b);
  assign gt = ($signed(a) > $signed(b));
endmodule

// ----- design/bounded_list_engine_unit.sv -----
// bounded deque of signed 32-bit words with sorted insert, search and sort.
// one command is taken at a time; in_ready drops from the input transfer until
// the cycle after the result is transferred out. push, pop, ignored commands
// and unused opcodes go straight to the result, and a read makes one store
// access. count, contains, is-sorted and sorted insert walk the live entries
// at most once through the store with registered read, one read per entry
// visited. sorted insert walks to the insertion point, then shifts the rest
// back one entry at a time. sort is insertion sort. the store has one read and
// one write port and one comparator serves every walk. entries are never
// cleared; results are only taken from live slots.
module bounded_list_engine_unit
  import ble_pkg::*;
#(
  parameter int CAPACITY = DefCapacity
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [OpWidth-1:0]            opcode,
  input  logic signed [ValueWidth-1:0]  value,
  input  logic [PosWidth-1:0]           position,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [StatusWidth-1:0]        status,
  output logic signed [ValueWidth-1:0]  answer,
  output logic [LenWidth-1:0]           length
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_RDW, S_EVAL, S_SH_RD, S_SH_RDW, S_SH_WR,
    S_SO_KEY, S_SO_KEYW, S_SO_RD, S_SO_RDW, S_SO_EVAL, S_DONE
  } state_t;

  state_t               state;
  logic [ValueWidth-1:0] mem [CAPACITY];
  logic [ValueWidth-1:0] rdata;
  logic [AW-1:0]        raddr;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [ValueWidth-1:0] wdata;

  logic [AW-1:0]        head;
  logic [CW-1:0]        count;
  op_t                  op;
  logic [ValueWidth-1:0] val;
  logic [ValueWidth-1:0] prev;
  logic [ValueWidth-1:0] key;
  logic [CW-1:0]        idx;
  logic [CW-1:0]        jdx;
  logic [CW-1:0]        acc;

  logic cmp_eq, cmp_gt;
  logic [ValueWidth-1:0] cmp_a, cmp_b;

  // single store port pair
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // logical index to physical slot, wrapping modulo capacity
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] i);
    logic [CW:0] s;
    s = {{(CW+1-AW){1'b0}}, h} + {1'b0, i};
    if (s >= (CW+1)'(CAPACITY)) s = s - (CW+1)'(CAPACITY);
    return s[AW-1:0];
  endfunction

  // comparator operands depend on which walk is running
  always_comb begin
    cmp_a = rdata;
    cmp_b = val;
    if (op == OP_IS_SORTED) begin
      cmp_a = prev;
      cmp_b = rdata;
    end else if (op == OP_SORT) begin
      cmp_a = rdata;
      cmp_b = key;
    end
  end

  ble_cmp u_cmp (.a(cmp_a), .b(cmp_b), .eq(cmp_eq), .gt(cmp_gt));

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign length   = LenWidth'(count);

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = val;
    raddr = slot(head, idx);
    // hold the shift source address until its word has been registered
    if (state == S_SH_RD || state == S_SH_RDW) raddr = slot(head, jdx - 1'b1);
    if (state == S_SO_RD || state == S_SO_RDW) raddr = slot(head, jdx - 1'b1);
    if (state == S_SO_KEY) raddr = slot(head, idx);
    if (state == S_IDLE && in_valid && in_ready) begin
      unique case (op_t'(opcode))
        OP_PUSH_HEAD: begin
          we = (count < CW'(CAPACITY));
          waddr = slot(head, CW'(CAPACITY - 1));
          wdata = value;
        end
        OP_PUSH_TAIL: begin
          we = (count < CW'(CAPACITY));
          waddr = slot(head, count);
          wdata = value;
        end
        OP_PUSH_BOTH: begin
          we = ({1'b0, count} + 1'b1 < (CW+1)'(CAPACITY));
          waddr = slot(head, CW'(CAPACITY - 1));
          wdata = value;
        end
        default: ;
      endcase
    end
    if (state == S_DONE && op == OP_PUSH_BOTH && idx == '0) begin
      we = 1'b1;
      waddr = slot(head, count - 1'b1);
    end
    // insert word lands at its slot once the walk and shift are finished
    if (state == S_DONE && op == OP_INSERT && status == ST_OK) begin
      we = 1'b1;
      waddr = slot(head, idx);
    end
    if (state == S_SH_WR) begin
      we = 1'b1;
      waddr = slot(head, jdx);
      wdata = rdata;
    end
    if (state == S_SO_EVAL) begin
      we = 1'b1;
      waddr = slot(head, jdx);
      wdata = (cmp_gt && jdx != '0) ? rdata : key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
      op        <= OP_READ;
    end else begin
      if (state == S_DONE) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            op  <= op_t'(opcode);
            val <= value;
            acc <= '0;
            unique case (op_t'(opcode))
              OP_PUSH_HEAD, OP_PUSH_TAIL: begin
                idx    <= '0;
                answer <= '0;
                state  <= S_DONE;
                if (count >= CW'(CAPACITY)) status <= ST_FULL;
                else begin
                  status <= ST_OK;
                  count  <= count + 1'b1;
                  if (opcode == OP_PUSH_HEAD) head <= slot(head, CW'(CAPACITY - 1));
                end
              end
              OP_PUSH_BOTH: begin
                answer <= '0;
                state  <= S_DONE;
                if ({1'b0, count} + 2'd2 > (CW+1)'(CAPACITY)) begin
                  status <= ST_FULL;
                  idx    <= CW'(1);
                end else begin
                  status <= ST_OK;
                  idx    <= '0;
                  head   <= slot(head, CW'(CAPACITY - 1));
                  count  <= count + 2'd2;
                end
              end
              OP_POP_HEAD, OP_POP_TAIL, OP_POP_BOTH: begin
                idx    <= '0;
                answer <= '0;
                state  <= S_DONE;
                if (count == '0) status <= ST_EMPTY;
                else begin
                  status <= ST_OK;
                  if (opcode == OP_POP_TAIL) count <= count - 1'b1;
                  else begin
                    head <= slot(head, CW'(1));
                    if (opcode == OP_POP_BOTH && count > CW'(1)) count <= count - 2'd2;
                    else count <= count - 1'b1;
                  end
                end
              end
              OP_INSERT: begin
                idx    <= '0;
                answer <= '0;
                if (count >= CW'(CAPACITY)) begin
                  status <= ST_FULL;
                  state  <= S_DONE;
                end else begin
                  status <= ST_OK;
                  state  <= S_RD;
                end
              end
              OP_COUNT, OP_CONTAINS: begin
                idx    <= '0;
                answer <= '0;
                status <= ST_OK;
                state  <= S_RD;
              end
              OP_IS_SORTED: begin
                idx    <= '0;
                answer <= 32'sd1;
                status <= ST_OK;
                if (count > CW'(1)) state <= S_RD;
                else state <= S_DONE;
              end
              OP_SORT: begin
                idx    <= CW'(1);
                answer <= '0;
                status <= ST_OK;
                if (count > CW'(1)) state <= S_SO_KEY;
                else state <= S_DONE;
              end
              OP_READ: begin
                answer <= '0;
                if (CW'(position) >= count) begin
                  status <= ST_RANGE;
                  idx    <= '0;
                  state  <= S_DONE;
                end else begin
                  status <= ST_OK;
                  idx    <= CW'(position);
                  state  <= S_RD;
                end
              end
              default: begin
                idx    <= '0;
                answer <= '0;
                status <= ST_OK;
                state  <= S_DONE;
              end
            endcase
          end
        end
        S_RD: state <= S_RDW;
        S_RDW: state <= S_EVAL;
        S_EVAL: begin
          unique case (op)
            OP_READ: begin
              answer <= rdata;
              state  <= S_DONE;
            end
            OP_COUNT: begin
              if (idx >= count) begin
                answer <= ValueWidth'(acc);
                state  <= S_DONE;
              end else begin
                if (cmp_eq) acc <= acc + 1'b1;
                idx   <= idx + 1'b1;
                state <= S_RD;
              end
            end
            OP_CONTAINS: begin
              if (idx >= count) state <= S_DONE;
              else if (cmp_eq) begin
                answer <= 32'sd1;
                state  <= S_DONE;
              end else begin
                idx   <= idx + 1'b1;
                state <= S_RD;
              end
            end
            OP_IS_SORTED: begin
              prev <= rdata;
              if (idx != '0 && cmp_gt) begin
                answer <= '0;
                state  <= S_DONE;
              end else if (idx + 1'b1 >= count) state <= S_DONE;
              else begin
                idx   <= idx + 1'b1;
                state <= S_RD;
              end
            end
            default: begin
              // sorted insert: stop at first entry greater than the word
              if (idx >= count || cmp_gt) begin
                jdx <= count;
                if (idx == count) begin
                  count <= count + 1'b1;
                  state <= S_DONE;
                end else state <= S_SH_RD;
              end else begin
                idx   <= idx + 1'b1;
                state <= S_RD;
              end
            end
          endcase
        end
        S_SH_RD: state <= S_SH_RDW;
        S_SH_RDW: state <= S_SH_WR;
        S_SH_WR: begin
          jdx <= jdx - 1'b1;
          if (jdx - 1'b1 == idx) begin
            count <= count + 1'b1;
            state <= S_DONE;
          end else state <= S_SH_RD;
        end
        S_SO_KEY: state <= S_SO_KEYW;
        S_SO_KEYW: begin
          key   <= rdata;
          jdx   <= idx;
          state <= S_SO_RD;
        end
        S_SO_RD: state <= S_SO_RDW;
        S_SO_RDW: state <= S_SO_EVAL;
        S_SO_EVAL: begin
          if (cmp_gt && jdx != '0) begin
            jdx <= jdx - 1'b1;
            if (jdx - 1'b1 == '0) state <= S_SO_EVAL;
            else state <= S_SO_RD;
          end else if (idx + 1'b1 >= count) state <= S_DONE;
          else begin
            idx   <= idx + 1'b1;
            state <= S_SO_KEY;
          end
        end
        S_DONE: begin
          // final write of the insert word at its place, and of the tail copy of a push-both
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- tb/tb_bounded_list_engine_unit.sv -----
module tb_bounded_list_engine_unit;
  import ble_pkg::*;

  localparam int Cap = DefCapacity;
  localparam int StallLimit = 40000;

  // golden copy of the deque, kept as a plain queue from head to tail
  class deque_scoreboard;
    logic signed [ValueWidth-1:0] seq[$];
    logic [StatusWidth-1:0]       st_q[$];
    logic signed [ValueWidth-1:0] ans_q[$];
    logic [LenWidth-1:0]          len_q[$];
    int errors = 0;

    function void note_command(logic [OpWidth-1:0] op, logic signed [ValueWidth-1:0] v,
                               logic [PosWidth-1:0] pos);
      status_t st;
      logic signed [ValueWidth-1:0] ans;
      logic signed [ValueWidth-1:0] key;
      int k;
      int j;
      st = ST_OK;
      ans = '0;
      case (op)
        OP_PUSH_HEAD: if (seq.size() >= Cap) st = ST_FULL; else seq.push_front(v);
        OP_PUSH_TAIL: if (seq.size() >= Cap) st = ST_FULL; else seq.push_back(v);
        OP_PUSH_BOTH: if (seq.size() + 2 > Cap) st = ST_FULL;
                      else begin seq.push_front(v); seq.push_back(v); end
        OP_POP_HEAD: if (seq.size() == 0) st = ST_EMPTY; else void'(seq.pop_front());
        OP_POP_TAIL: if (seq.size() == 0) st = ST_EMPTY; else void'(seq.pop_back());
        OP_POP_BOTH: if (seq.size() == 0) st = ST_EMPTY;
                     else begin
                       void'(seq.pop_front());
                       if (seq.size() > 0) void'(seq.pop_back());
                     end
        OP_INSERT: if (seq.size() >= Cap) st = ST_FULL;
                   else begin
                     // goes after the leading entries <= v, before the first greater one
                     k = 0;
                     while (k < seq.size() && seq[k] <= v) k++;
                     seq.insert(k, v);
                   end
        OP_COUNT: foreach (seq[i]) if (seq[i] == v) ans++;
        OP_CONTAINS: foreach (seq[i]) if (seq[i] == v) ans = 1;
        OP_IS_SORTED: begin
          ans = 1;
          for (int i = 1; i < seq.size(); i++) if (seq[i] < seq[i-1]) ans = 0;
        end
        OP_SORT: for (int i = 1; i < seq.size(); i++) begin
          key = seq[i];
          j = i;
          while (j > 0 && seq[j-1] > key) begin seq[j] = seq[j-1]; j--; end
          seq[j] = key;
        end
        OP_READ: if (pos >= seq.size()) st = ST_RANGE; else ans = seq[pos];
        default: ;
      endcase
      st_q.push_back(st);
      ans_q.push_back(ans);
      len_q.push_back(LenWidth'(seq.size()));
    endfunction

    function void check_result(logic [StatusWidth-1:0] st, logic signed [ValueWidth-1:0] ans,
                               logic [LenWidth-1:0] len);
      if (st_q.size() == 0) begin
        $error("result with nothing outstanding: status %0d answer %0d length %0d",
               st, ans, len);
        errors++;
        return;
      end
      if (st !== st_q[0]) begin
        $error("status: expected %0d got %0d", st_q[0], st); errors++;
      end
      if (ans !== ans_q[0]) begin
        $error("answer: expected %0d got %0d", ans_q[0], ans); errors++;
      end
      if (len !== len_q[0]) begin
        $error("length: expected %0d got %0d", len_q[0], len); errors++;
      end
      void'(st_q.pop_front());
      void'(ans_q.pop_front());
      void'(len_q.pop_front());
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [OpWidth-1:0]           opcode = '0;
  logic signed [ValueWidth-1:0] value = '0;
  logic [PosWidth-1:0]          position = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [StatusWidth-1:0]       status;
  logic signed [ValueWidth-1:0] answer;
  logic [LenWidth-1:0]          length;

  deque_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  bounded_list_engine_unit u_top (
    .clk, .rst, .in_valid, .in_ready, .opcode, .value, .position,
    .out_valid, .out_ready, .status, .answer, .length
  );

  // sample both handshakes at the rising edge; model updates on input transfer
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_command(opcode, value, position);
      if (out_valid && out_ready) sb.check_result(status, answer, length);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (quiet_cycles >= StallLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver stalls at random, at the falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // valid stays up from one transfer to the next unless the sender idles
  task automatic send_command(logic [OpWidth-1:0] op, logic signed [ValueWidth-1:0] v,
                              logic [PosWidth-1:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    opcode   <= op;
    value    <= v;
    position <= pos;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // values mostly from a small pool so count and contains hit often
  function automatic logic signed [ValueWidth-1:0] pick_value();
    case ($urandom_range(3))
      0: return $urandom();
      1: return ValueWidth'(32'sh7fff_fffd + $urandom_range(5));
      default: return ValueWidth'($signed($urandom_range(8)) - 4);
    endcase
  endfunction

  task automatic random_phase(int n);
    logic [OpWidth-1:0] op;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      // drift toward full so the full edge is visited
      if (r < 30) op = OpWidth'(OP_PUSH_HEAD + $urandom_range(2));
      else if (r < 45) op = OpWidth'(OP_POP_HEAD + $urandom_range(2));
      else if (r < 60) op = OP_INSERT;
      else if (r < 94) op = OpWidth'(OP_COUNT + $urandom_range(4));
      else if (r < 97) op = OP_SORT;
      else op = 4'($urandom_range(12, 15));
      send_command(op, pick_value(), 6'($urandom()));
    end
  endtask

  initial begin
    int phase_idle[4];
    int phase_stall[4];
    phase_idle  = '{0, 51, 0, 21};
    phase_stall = '{0, 0, 51, 21};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty edge cases, extremes, then fill to capacity
    send_command(OP_POP_HEAD, 0, 6'd0);
    send_command(OP_POP_TAIL, 0, 6'd0);
    send_command(OP_POP_BOTH, 0, 6'd0);
    send_command(OP_COUNT, 0, 6'd0);
    send_command(OP_CONTAINS, 0, 6'd0);
    send_command(OP_IS_SORTED, 0, 6'd0);
    send_command(OP_SORT, 0, 6'd0);
    send_command(OP_READ, 0, 6'd0);
    send_command(OP_PUSH_HEAD, 32'sh7fff_ffff, 6'd0);
    send_command(OP_PUSH_TAIL, 32'sh8000_0000, 6'd0);
    send_command(OP_PUSH_BOTH, -1, 6'd0);
    send_command(OP_IS_SORTED, 0, 6'd0);
    send_command(OP_INSERT, 5, 6'd0);
    send_command(OP_COUNT, -1, 6'd0);
    send_command(OP_CONTAINS, 32'sh8000_0000, 6'd0);
    send_command(OP_SORT, 0, 6'd0);
    send_command(OP_READ, 0, 6'd4);
    send_command(OP_READ, 0, 6'd63);
    send_command(4'd15, 0, 6'd0);
    send_command(OP_POP_BOTH, 0, 6'd0);
    for (int i = 0; i < 64; i++) send_command(OP_PUSH_TAIL, pick_value(), 6'd0);
    send_command(OP_PUSH_HEAD, 1, 6'd0);
    send_command(OP_PUSH_BOTH, 1, 6'd0);
    send_command(OP_INSERT, 1, 6'd0);
    send_command(OP_READ, 0, 6'd63);
    send_command(OP_SORT, 0, 6'd0);
    send_command(OP_IS_SORTED, 0, 6'd0);
    send_command(OP_POP_HEAD, 0, 6'd0);
    send_command(OP_PUSH_BOTH, 1, 6'd0);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      random_phase(400);
    end
    in_valid <= 1'b0;

    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (sb.st_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.st_q.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
